// File: hw/rtl/max_subarray_xor_trie_macros.svh
// Assertion macros for the maximum subarray XOR block
`ifndef MAX_SUBARRAY_XOR_TRIE_MACROS_SVH
`define MAX_SUBARRAY_XOR_TRIE_MACROS_SVH

// same-cycle implication
`define MXT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MXT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/mxt_pkg.sv
// Request and result types for the maximum subarray XOR block
package mxt_pkg;

  localparam int ELEM_W = 31;
  localparam int BEST_W = 31;

  typedef struct packed {
    logic [ELEM_W-1:0] element_value;
    logic              last;
  } in_req_t;

  typedef struct packed {
    logic [BEST_W-1:0] best_xor;
    logic              is_last;
    logic              overflow;
  } out_res_t;

endpackage

// File: hw/rtl/mxt_mem.sv
// Trie node store: one write port, one read port, registered read data
module mxt_mem #(
  parameter int DEPTH  = 32769,
  parameter int DATA_W = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/max_subarray_xor_trie.sv
// Maximum subarray XOR: prefix trie walker and node store
//
//  channel  ports                    handshake
//  request  in_req (start, busy)     taken when start && !busy
//  result   out_res (out_strobe)     one cycle per request, no back-pressure
//
// Per request: an accept step, a query walk from the top level down (one node
// read per level), the result strobe, then an insert walk of one memory access
// per step; the last element of an array skips the insert and reseeds instead.
// A dropped request (capacity reached) returns its result in the next cycle.
// Reset, and the end of each array, seed the trie with the zero prefix:
// VALUE_BITS+1 writes while busy is high. The receiver cannot stall.
`include "max_subarray_xor_trie_macros.svh"

module max_subarray_xor_trie #(
  parameter int VALUE_BITS   = 32,
  parameter int MAX_ELEMENTS = 1023
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mxt_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output mxt_pkg::out_res_t out_res
);

  import mxt_pkg::*;

  localparam int TRIE_DEPTH = 1 + (MAX_ELEMENTS + 1) * VALUE_BITS;
  localparam int NODE_W     = $clog2(TRIE_DEPTH);
  localparam int CNT_W      = $clog2(TRIE_DEPTH + 1);
  localparam int LVL_W      = $clog2(VALUE_BITS);
  localparam int ECNT_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int ENTRY_W    = 2 * NODE_W;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(VALUE_BITS - 1);

  typedef enum logic [4:0] {
    SEED = 5'b00001,
    IDLE = 5'b00010,
    QRY  = 5'b00100,
    INS  = 5'b01000,
    FILL = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LVL_W-1:0]        lvl_r, lvl_nxt;
  logic [NODE_W-1:0]       cur_r, cur_nxt;
  logic [CNT_W-1:0]        nodes_r, nodes_nxt;
  logic [VALUE_BITS-1:0]   prefix_r, prefix_nxt;
  logic [VALUE_BITS-1:0]   best_r, best_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;
  logic [ECNT_W-1:0]       ecnt_r, ecnt_nxt;
  logic                    drop_r, drop_nxt;
  logic                    last_r, last_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  out_res_t                out_res_r, out_res_nxt;

  logic                    wr_en, rd_en;
  logic [NODE_W-1:0]       wr_addr, rd_addr;
  logic [ENTRY_W-1:0]      wr_data, rd_data;

  logic                    accept;
  logic [31:0]             elem_w;
  logic [VALUE_BITS-1:0]   elem_v;
  logic [NODE_W-1:0]       link0, link1, link_same, link_opp;
  logic                    bit_q, bit_f;
  logic [VALUE_BITS-1:0]   lvl_bit;
  logic [VALUE_BITS-1:0]   best_new;
  logic [31:0]             best_w;
  logic [NODE_W-1:0]       new_link, next_link;

  mxt_mem #(
    .DEPTH  (TRIE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy       = (state_r != IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  assign elem_w    = 32'(in_req.element_value);
  assign elem_v    = elem_w[VALUE_BITS-1:0];
  assign link0     = rd_data[NODE_W-1:0];
  assign link1     = rd_data[ENTRY_W-1:NODE_W];
  assign bit_q     = prefix_r[lvl_r];
  assign bit_f     = prefix_r[lvl_r - 1'b1];
  assign link_same = bit_q ? link1 : link0;
  assign link_opp  = bit_q ? link0 : link1;
  assign lvl_bit   = VALUE_BITS'(1) << lvl_r;
  assign new_link  = nodes_r[NODE_W-1:0];
  assign next_link = NODE_W'(nodes_r + 1'b1);

  // accesses are serialised by the sequencer, so no forwarding is needed
  always_comb begin
    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    cur_nxt        = cur_r;
    nodes_nxt      = nodes_r;
    prefix_nxt     = prefix_r;
    best_nxt       = best_r;
    acc_nxt        = acc_r;
    ecnt_nxt       = ecnt_r;
    drop_nxt       = drop_r;
    last_nxt       = last_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    best_new       = best_r;
    best_w         = 32'(best_r);

    unique case (state_r)
      SEED: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = {{NODE_W{1'b0}}, NODE_W'(1)};
        nodes_nxt  = CNT_W'(1);
        lvl_nxt    = TOP_LVL;
        prefix_nxt = '0;
        best_nxt   = '0;
        ecnt_nxt   = '0;
        drop_nxt   = 1'b0;
        state_nxt  = FILL;
      end
      IDLE: begin
        if (accept) begin
          if (ecnt_r >= ECNT_W'(MAX_ELEMENTS)) begin
            drop_nxt       = 1'b1;
            out_strobe_nxt = 1'b1;
            out_res_nxt    = '{best_xor: best_w[BEST_W-1:0], is_last: in_req.last,
                               overflow: 1'b1};
            state_nxt      = in_req.last ? SEED : IDLE;
          end else begin
            prefix_nxt = prefix_r ^ elem_v;
            ecnt_nxt   = ecnt_r + 1'b1;
            last_nxt   = in_req.last;
            acc_nxt    = '0;
            rd_en      = 1'b1;
            rd_addr    = '0;
            lvl_nxt    = TOP_LVL;
            state_nxt  = QRY;
          end
        end
      end
      QRY: begin
        if (link_opp != '0) begin
          acc_nxt = acc_r | lvl_bit;
        end
        if (lvl_r == '0) begin
          best_new       = (acc_nxt > best_r) ? acc_nxt : best_r;
          best_w         = 32'(best_new);
          best_nxt       = best_new;
          out_strobe_nxt = 1'b1;
          out_res_nxt    = '{best_xor: best_w[BEST_W-1:0], is_last: last_r,
                             overflow: drop_r};
          if (last_r) begin
            state_nxt = SEED;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            cur_nxt   = '0;
            lvl_nxt   = TOP_LVL;
            state_nxt = INS;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = (link_opp != '0) ? link_opp : link_same;
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      INS: begin
        if (link_same != '0) begin
          if (lvl_r == '0) begin
            state_nxt = IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = link_same;
            cur_nxt = link_same;
            lvl_nxt = lvl_r - 1'b1;
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = cur_r;
          wr_data   = bit_q ? {new_link, link0} : {link1, new_link};
          state_nxt = FILL;
        end
      end
      FILL: begin
        // fresh chain below a missing link, or the seed chain: one new node per write
        wr_en     = 1'b1;
        wr_addr   = nodes_r[NODE_W-1:0];
        nodes_nxt = nodes_r + 1'b1;
        if (lvl_r == '0) begin
          wr_data   = '0;
          state_nxt = IDLE;
        end else begin
          wr_data = bit_f ? {next_link, {NODE_W{1'b0}}} : {{NODE_W{1'b0}}, next_link};
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      default: begin
        state_nxt = SEED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SEED;
      out_strobe_r <= 1'b0;
      ecnt_r       <= '0;
      drop_r       <= 1'b0;
      best_r       <= '0;
      prefix_r     <= '0;
      nodes_r      <= CNT_W'(1);
      lvl_r        <= TOP_LVL;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      ecnt_r       <= ecnt_nxt;
      drop_r       <= drop_nxt;
      best_r       <= best_nxt;
      prefix_r     <= prefix_nxt;
      nodes_r      <= nodes_nxt;
      lvl_r        <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    acc_r     <= acc_nxt;
    last_r    <= last_nxt;
    out_res_r <= out_res_nxt;
  end

  `MXT_ASSERT_NXT(a_qry_end_strobe, clk, rst_n, (state_r == QRY) && (lvl_r == '0),
                  out_strobe, "query end without result strobe")
  `MXT_ASSERT_NXT(a_seed_fill, clk, rst_n, state_r == SEED,
                  (state_r == FILL) && (nodes_r == CNT_W'(1)), "seed did not start fill")
  `MXT_ASSERT_NXT(a_fill_alloc, clk, rst_n, state_r == FILL,
                  nodes_r == CNT_W'($past(nodes_r) + 1'b1), "fill did not allocate a node")
  `MXT_ASSERT_IMP(a_strobe_src, clk, rst_n, out_strobe,
                  $past(state_r == QRY) || $past(start && !busy), "unexpected result strobe")

endmodule

// File: tb/max_subarray_xor_trie_test.sv
// Self-checking testbench for the maximum subarray XOR block: directed, random and capacity runs
`timescale 1ns / 100ps

module max_subarray_xor_trie_test;
  import mxt_pkg::*;

  localparam int VALUE_BITS   = 32;
  localparam int MAX_ELEMENTS = 1023;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * VALUE_BITS + 40;

  class max_xor_tracker;
    logic [VALUE_BITS-1:0] prefix;
    logic [VALUE_BITS-1:0] best;
    logic [VALUE_BITS-1:0] prefixes[$];
    int unsigned           count;
    bit                    dropped;
    out_res_t              expected_res[$];
    int unsigned           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      prefixes = {};
      prefixes.push_back('0);
      prefix  = '0;
      best    = '0;
      count   = 0;
      dropped = 1'b0;
    endfunction

    function void note_request(in_req_t r);
      logic [VALUE_BITS-1:0] elem;
      logic [VALUE_BITS-1:0] cand;
      out_res_t              res;
      if (count >= MAX_ELEMENTS) begin
        dropped = 1'b1;
      end else begin
        elem   = VALUE_BITS'(r.element_value);
        prefix = prefix ^ elem;
        cand   = '0;
        foreach (prefixes[i]) begin
          if ((prefix ^ prefixes[i]) > cand) begin
            cand = prefix ^ prefixes[i];
          end
        end
        if (cand > best) begin
          best = cand;
        end
        prefixes.push_back(prefix);
        count++;
      end
      res.best_xor = best[BEST_W-1:0];
      res.is_last  = r.last;
      res.overflow = dropped;
      expected_res.push_back(res);
      if (r.last) begin
        restart();
      end
    endfunction

    function void check_result(out_res_t got);
      out_res_t exp;
      if (expected_res.size() == 0) begin
        errors++;
        $error("unexpected result: best_xor=%h is_last=%b overflow=%b",
               got.best_xor, got.is_last, got.overflow);
        return;
      end
      exp = expected_res.pop_front();
      if (got.best_xor !== exp.best_xor) begin
        errors++;
        $error("best_xor: expected %h, got %h", exp.best_xor, got.best_xor);
      end
      if (got.is_last !== exp.is_last) begin
        errors++;
        $error("is_last: expected %b, got %b", exp.is_last, got.is_last);
      end
      if (got.overflow !== exp.overflow) begin
        errors++;
        $error("overflow: expected %b, got %b", exp.overflow, got.overflow);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_strobe;
  out_res_t out_res;

  max_xor_tracker tracker = new();
  int             burst_left;
  int             cycle_count;

  max_subarray_xor_trie #(
    .VALUE_BITS  (VALUE_BITS),
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      tracker.check_result(out_res);
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("max_subarray_xor_trie_test: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(3))
      0:       return ELEM_W'($urandom_range(15));
      1:       return ELEM_W'(1) << $urandom_range(ELEM_W - 1);
      2:       return ELEM_W'($urandom) | {1'b1, {(ELEM_W-1){1'b0}}};
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic [ELEM_W-1:0] value, input logic last);
    in_req_t r;
    r.element_value = value;
    r.last          = last;
    if (burst_left <= 0) begin
      start  <= 1'b0;
      in_req <= in_req_t'($urandom);
      repeat (($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 8))
        @(negedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    tracker.note_request(r);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_array(input int len);
    for (int i = 0; i < len; i++) begin
      send_req(rand_elem(), i == len - 1);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, single-element arrays, repeats, alternating patterns
    send_req('0, 1'b1);
    send_req({ELEM_W{1'b1}}, 1'b1);
    send_req({ELEM_W{1'b1}}, 1'b0);
    send_req({ELEM_W{1'b1}}, 1'b0);
    send_req('0, 1'b0);
    send_req(31'h5555_5555, 1'b1);
    send_req(31'h2AAA_AAAA, 1'b0);
    send_req(31'h5555_5555, 1'b0);
    send_req(31'h0000_0001, 1'b0);
    send_req(31'h4000_0000, 1'b1);
    send_req(31'd5, 1'b0);
    send_req(31'd5, 1'b0);
    send_req(31'd5, 1'b1);
    for (int b = 0; b < 6; b++) begin
      send_req(ELEM_W'(1) << (b * 6), b == 5);
    end
    send_req(31'h7FFF_0000, 1'b0);
    send_req(31'h0000_FFFF, 1'b1);

    for (int a = 0; a < 8; a++) begin
      send_array($urandom_range(1, 12));
    end

    // fills the array past capacity; the final, dropped request ends it
    for (int i = 0; i < MAX_ELEMENTS + 12; i++) begin
      send_req(rand_elem(), i == MAX_ELEMENTS + 11);
    end

    for (int a = 0; a < 6; a++) begin
      send_array($urandom_range(1, 12));
    end

    start <= 1'b0;
    while (tracker.expected_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("max_subarray_xor_trie_test: PASS");
    end else begin
      $display("max_subarray_xor_trie_test: FAIL");
    end
    $finish;
  end

endmodule
